// ----- rtl/core/imhdk_pkg.sv -----
package imhdk_pkg;

    localparam int CAPACITY = 1024;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CHILD_W = SLOT_W + 1;
    localparam int ID_W = 10;
    localparam int KEY_W = 31;
    localparam int NUM_IDS = 1 << ID_W;
    localparam int CMD_W = 2;
    localparam int STATUS_W = 2;
    localparam int ENTRY_COUNT_W = 11;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [CHILD_W-1:0] child_t;
    typedef logic [ID_W-1:0] id_t;
    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD     = 2'd0,
        CMD_EXTRACT  = 2'd1,
        CMD_DECREASE = 2'd2
    } cmd_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_e;

    typedef struct packed {
        id_t  id;
        key_t key;
    } entry_t;

    typedef struct packed {
        logic   en;
        slot_t  addr;
        entry_t data;
    } heap_wr_t;

    typedef struct packed {
        logic  en;
        id_t   addr;
        slot_t data;
    } pos_wr_t;

    typedef struct packed {
        id_t                      id;
        key_t                     key;
        logic                     was_member;
        logic [STATUS_W-1:0]      status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } result_t;

    function automatic slot_t parent_of(slot_t s);
        slot_t d;
        d = s - slot_t'(1);
        return d >> 1;
    endfunction

    function automatic child_t left_of(slot_t s);
        return {s, 1'b1};
    endfunction

endpackage

// ----- rtl/core/imhdk_heap_ram.sv -----
module imhdk_heap_ram (
    input  logic                clk,
    input  imhdk_pkg::heap_wr_t wr,
    input  imhdk_pkg::slot_t    rd_a_addr,
    input  imhdk_pkg::slot_t    rd_b_addr,
    output imhdk_pkg::entry_t   rd_a,
    output imhdk_pkg::entry_t   rd_b
);

    imhdk_pkg::entry_t mem [imhdk_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_a <= mem[rd_a_addr];
        rd_b <= mem[rd_b_addr];
    end

endmodule

// ----- rtl/core/imhdk_pos_ram.sv -----
module imhdk_pos_ram (
    input  logic               clk,
    input  imhdk_pkg::pos_wr_t wr,
    input  imhdk_pkg::id_t     rd_addr,
    output imhdk_pkg::slot_t   rd
);

    imhdk_pkg::slot_t mem [imhdk_pkg::NUM_IDS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/imhdk_seq.sv -----
module imhdk_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [imhdk_pkg::CMD_W-1:0]         cmd,
    input  imhdk_pkg::id_t                      item_id,
    input  imhdk_pkg::key_t                     new_key,
    output imhdk_pkg::heap_wr_t                 heap_wr,
    output imhdk_pkg::slot_t                    heap_rd_a_addr,
    output imhdk_pkg::slot_t                    heap_rd_b_addr,
    input  imhdk_pkg::entry_t                   heap_rd_a,
    input  imhdk_pkg::entry_t                   heap_rd_b,
    output imhdk_pkg::pos_wr_t                  pos_wr,
    output imhdk_pkg::id_t                      pos_rd_addr,
    input  imhdk_pkg::slot_t                    pos_rd,
    output logic                                res_valid,
    input  logic                                res_ready,
    output imhdk_pkg::result_t                  res
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_POS  = 6'b000010,
        S_MEM  = 6'b000100,
        S_UP   = 6'b001000,
        S_DN   = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                            state_reg, state_next;
    logic [imhdk_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    imhdk_pkg::id_t                    id_reg, id_next;
    imhdk_pkg::key_t                   key_reg, key_next;
    imhdk_pkg::cnt_t                   count_reg, count_next;
    imhdk_pkg::slot_t                  slot_reg, slot_next;
    imhdk_pkg::entry_t                 mov_reg, mov_next;
    imhdk_pkg::entry_t                 top_reg, top_next;
    imhdk_pkg::entry_t                 last_reg, last_next;
    logic                              member_reg, member_next;
    logic [imhdk_pkg::STATUS_W-1:0]    status_reg, status_next;
    imhdk_pkg::id_t                    res_id_reg, res_id_next;
    imhdk_pkg::key_t                   res_key_reg, res_key_next;

    imhdk_pkg::slot_t                  last_slot;
    logic                              member;
    logic                              full;
    imhdk_pkg::child_t                 left_c, right_c;
    logic                              left_ok, right_ok;
    logic                              pick_l, pick_r;
    imhdk_pkg::key_t                   best_key;
    imhdk_pkg::child_t                 left_n, right_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        id_reg      <= id_next;
        key_reg     <= key_next;
        slot_reg    <= slot_next;
        mov_reg     <= mov_next;
        top_reg     <= top_next;
        last_reg    <= last_next;
        member_reg  <= member_next;
        status_reg  <= status_next;
        res_id_reg  <= res_id_next;
        res_key_reg <= res_key_next;
    end

    assign last_slot = imhdk_pkg::slot_t'(count_reg - imhdk_pkg::cnt_t'(1));
    assign member    = (imhdk_pkg::cnt_t'(pos_rd) < count_reg) && (heap_rd_a.id == id_reg);
    assign full      = count_reg >= imhdk_pkg::cnt_t'(imhdk_pkg::CAPACITY);

    assign left_c   = imhdk_pkg::left_of(slot_reg);
    assign right_c  = left_c + imhdk_pkg::child_t'(1);
    assign left_ok  = left_c < imhdk_pkg::child_t'(count_reg);
    assign right_ok = right_c < imhdk_pkg::child_t'(count_reg);
    assign pick_l   = left_ok && (heap_rd_a.key < mov_reg.key);
    assign best_key = pick_l ? heap_rd_a.key : mov_reg.key;
    assign pick_r   = right_ok && (heap_rd_b.key < best_key);

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        id_next      = id_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        slot_next    = slot_reg;
        mov_next     = mov_reg;
        top_next     = top_reg;
        last_next    = last_reg;
        member_next  = member_reg;
        status_next  = status_reg;
        res_id_next  = res_id_reg;
        res_key_next = res_key_reg;
        heap_wr      = '0;
        pos_wr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    id_next    = item_id;
                    key_next   = new_key;
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                top_next   = heap_rd_a;
                last_next  = heap_rd_b;
                state_next = S_MEM;
            end
            S_MEM:
            begin
                member_next  = member;
                status_next  = imhdk_pkg::ST_OK;
                res_id_next  = '0;
                res_key_next = '0;
                state_next   = S_DONE;
                case (cmd_reg)
                    imhdk_pkg::CMD_LOAD:
                    begin
                        if (!member)
                        begin
                            if (full)
                            begin
                                status_next = imhdk_pkg::ST_FULL;
                            end
                            else
                            begin
                                slot_next  = imhdk_pkg::slot_t'(count_reg);
                                count_next = count_reg + imhdk_pkg::cnt_t'(1);
                                mov_next   = '{id: id_reg, key: key_reg};
                                state_next = S_UP;
                            end
                        end
                    end
                    imhdk_pkg::CMD_EXTRACT:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = imhdk_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            res_id_next  = top_reg.id;
                            res_key_next = top_reg.key;
                            pos_wr       = '{en: 1'b1, addr: top_reg.id, data: last_slot};
                            count_next   = count_reg - imhdk_pkg::cnt_t'(1);
                            mov_next     = last_reg;
                            slot_next    = '0;
                            state_next   = S_DN;
                        end
                    end
                    imhdk_pkg::CMD_DECREASE:
                    begin
                        if (member)
                        begin
                            slot_next  = pos_rd;
                            mov_next   = '{id: id_reg, key: key_reg};
                            state_next = S_UP;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_UP:
            begin
                if ((slot_reg != '0) && (mov_reg.key < heap_rd_a.key))
                begin
                    heap_wr   = '{en: 1'b1, addr: slot_reg, data: heap_rd_a};
                    pos_wr    = '{en: 1'b1, addr: heap_rd_a.id, data: slot_reg};
                    slot_next = imhdk_pkg::parent_of(slot_reg);
                end
                else
                begin
                    heap_wr    = '{en: 1'b1, addr: slot_reg, data: mov_reg};
                    pos_wr     = '{en: 1'b1, addr: mov_reg.id, data: slot_reg};
                    state_next = S_DONE;
                end
            end
            S_DN:
            begin
                if (pick_r)
                begin
                    heap_wr   = '{en: 1'b1, addr: slot_reg, data: heap_rd_b};
                    pos_wr    = '{en: 1'b1, addr: heap_rd_b.id, data: slot_reg};
                    slot_next = imhdk_pkg::slot_t'(right_c);
                end
                else if (pick_l)
                begin
                    heap_wr   = '{en: 1'b1, addr: slot_reg, data: heap_rd_a};
                    pos_wr    = '{en: 1'b1, addr: heap_rd_a.id, data: slot_reg};
                    slot_next = imhdk_pkg::slot_t'(left_c);
                end
                else
                begin
                    heap_wr    = '{en: 1'b1, addr: slot_reg, data: mov_reg};
                    pos_wr     = '{en: 1'b1, addr: mov_reg.id, data: slot_reg};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // read ahead for the next level while the current one is written back
    assign left_n  = imhdk_pkg::left_of(slot_next);
    assign right_n = left_n + imhdk_pkg::child_t'(1);

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            heap_rd_a_addr = '0;
            heap_rd_b_addr = last_slot;
        end
        else if (state_reg == S_POS)
        begin
            heap_rd_a_addr = pos_rd;
            heap_rd_b_addr = last_slot;
        end
        else if (state_next == S_DN)
        begin
            heap_rd_a_addr = imhdk_pkg::slot_t'(left_n);
            heap_rd_b_addr = imhdk_pkg::slot_t'(right_n);
        end
        else
        begin
            heap_rd_a_addr = imhdk_pkg::parent_of(slot_next);
            heap_rd_b_addr = imhdk_pkg::slot_t'(right_n);
        end
    end

    assign pos_rd_addr = (state_reg == S_IDLE) ? item_id : id_reg;
    assign in_stall    = state_reg != S_IDLE;
    assign res_valid   = state_reg == S_DONE;

    assign res.id          = res_id_reg;
    assign res.key         = res_key_reg;
    assign res.was_member  = member_reg;
    assign res.status      = status_reg;
    assign res.entry_count = imhdk_pkg::ENTRY_COUNT_W'(count_reg);

endmodule

// ----- rtl/core/indexed_min_heap_decrease_key.sv -----
// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall  cmd, item_id, new_key
// output    out        out_valid/ out_stall out_id, out_key, was_member, status, entry_count
//
// One word at a time: a lookup, a dispatch and a hand-off, plus a walk over the heap
// levels (sift up or down, final write included).
// The walk is a read-modify-write over the heap memory, one level a cycle.
// Reset clears the entry count and the sequencer; the memories need no clearing.
// A stalled output holds its word; the next input word is taken meanwhile.
module indexed_min_heap_decrease_key (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [imhdk_pkg::CMD_W-1:0]            cmd,
    input  logic [imhdk_pkg::ID_W-1:0]             item_id,
    input  logic [imhdk_pkg::KEY_W-1:0]            new_key,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [imhdk_pkg::ID_W-1:0]             out_id,
    output logic [imhdk_pkg::KEY_W-1:0]            out_key,
    output logic                                   was_member,
    output logic [imhdk_pkg::STATUS_W-1:0]         status,
    output logic [imhdk_pkg::ENTRY_COUNT_W-1:0]    entry_count
);

    imhdk_pkg::heap_wr_t heap_wr;
    imhdk_pkg::slot_t    heap_rd_a_addr, heap_rd_b_addr;
    imhdk_pkg::entry_t   heap_rd_a, heap_rd_b;
    imhdk_pkg::pos_wr_t  pos_wr;
    imhdk_pkg::id_t      pos_rd_addr;
    imhdk_pkg::slot_t    pos_rd;
    logic                res_valid;
    logic                res_ready;
    imhdk_pkg::result_t  res;

    logic                out_valid_reg, out_valid_next;
    imhdk_pkg::result_t  out_reg, out_next;

    imhdk_heap_ram u_heap_ram (
        .clk       (clk),
        .wr        (heap_wr),
        .rd_a_addr (heap_rd_a_addr),
        .rd_b_addr (heap_rd_b_addr),
        .rd_a      (heap_rd_a),
        .rd_b      (heap_rd_b)
    );

    imhdk_pos_ram u_pos_ram (
        .clk     (clk),
        .wr      (pos_wr),
        .rd_addr (pos_rd_addr),
        .rd      (pos_rd)
    );

    imhdk_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .item_id        (item_id),
        .new_key        (new_key),
        .heap_wr        (heap_wr),
        .heap_rd_a_addr (heap_rd_a_addr),
        .heap_rd_b_addr (heap_rd_b_addr),
        .heap_rd_a      (heap_rd_a),
        .heap_rd_b      (heap_rd_b),
        .pos_wr         (pos_wr),
        .pos_rd_addr    (pos_rd_addr),
        .pos_rd         (pos_rd),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_id      = out_reg.id;
    assign out_key     = out_reg.key;
    assign was_member  = out_reg.was_member;
    assign status      = out_reg.status;
    assign entry_count = out_reg.entry_count;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken without the sequencer going busy");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == imhdk_pkg::ST_FULL
        |-> entry_count == imhdk_pkg::ENTRY_COUNT_W'(imhdk_pkg::CAPACITY))
        else $error("full status with a count below capacity");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == imhdk_pkg::ST_EMPTY
        |-> entry_count == '0 && out_id == '0 && out_key == '0)
        else $error("empty status with entries or a nonzero word");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        heap_wr.en |-> in_stall && !res_valid)
        else $error("heap write outside the sift walk");

endmodule
